FILE: rtl/nv12ns_pkg.sv
// Shared types, constants and helper functions for the NV12 scale-to-RGB block.
package nv12ns_pkg;

    localparam int MAX_SOURCE_WIDTH  = 256;
    localparam int MAX_SOURCE_HEIGHT = 256;
    localparam int STORE_DEPTH       = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT * 3 / 2;
    localparam int STORE_AW          = $clog2(STORE_DEPTH);

    localparam int SIZE_W  = 9;
    localparam int DEST_W  = 12;
    localparam int NUM_W   = DEST_W + SIZE_W;
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int ADDR_W  = 31;
    localparam int CBASE_W = 2 * SIZE_W;
    localparam int ACC_W   = 25;
    localparam int OFS_W   = 26;
    localparam int MUL_AW  = 22;
    localparam int MUL_BW  = 17;
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int FRAC_W  = 14;

    localparam logic [0:0] OP_LOAD  = 1'b0;
    localparam logic [0:0] OP_FETCH = 1'b1;

    localparam logic [2:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_SOURCE_STRIDE = 3'd2;
    localparam logic [2:0] CFG_DEST_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_DEST_HEIGHT   = 3'd4;

    localparam logic [SIZE_W-1:0] RESET_SOURCE_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] RESET_SOURCE_HEIGHT = 9'd256;
    localparam logic [SIZE_W-1:0] RESET_SOURCE_STRIDE = 9'd0;
    localparam logic [DEST_W-1:0] RESET_DEST_WIDTH    = 12'd640;
    localparam logic [DEST_W-1:0] RESET_DEST_HEIGHT   = 12'd640;

    localparam logic signed [MUL_AW-1:0] COEF_RV = 22'sd22971;
    localparam logic signed [MUL_AW-1:0] COEF_GU = 22'sd5636;
    localparam logic signed [MUL_AW-1:0] COEF_GV = 22'sd11698;
    localparam logic signed [MUL_AW-1:0] COEF_BU = 22'sd29032;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_X,
        S_DIV_X,
        S_MUL_Y,
        S_DIV_Y,
        S_MUL_YA,
        S_MUL_CB,
        S_MUL_CA,
        S_RD_Y,
        S_RD_U,
        S_RD_V,
        S_CAP_V,
        S_CH_R,
        S_CH_G1,
        S_CH_G2,
        S_CH_B,
        S_OFF_MUL,
        S_OFF_ADD,
        S_OUT
    } seq_state_t;

    function automatic logic [7:0] clamp_channel(input logic signed [ACC_W-1:0] sum);
        logic [7:0] res;
        if (sum[ACC_W-1])
        begin
            res = 8'd0;
        end
        else if (|sum[ACC_W-2:FRAC_W+8])
        begin
            res = 8'd255;
        end
        else
        begin
            res = sum[FRAC_W+7:FRAC_W];
        end
        return res;
    endfunction

endpackage

FILE: rtl/nv12_nearest_scale_to_rgb.sv
// Top level: NV12 frame store, nearest-neighbour scaler and BT.601 RGB converter.
// A load word is written in its accept cycle; the next word may follow at once.
// A fetch word passes through the shared bit-per-cycle divider (21 steps for each of
// the two source coordinates) and the single shared multiplier before out_valid;
// the next word is taken the cycle after the result leaves.
// Reset restores the size registers to their defaults; the frame store is not cleared.
module nv12_nearest_scale_to_rgb (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [2:0]                            cfg_index,
    input  logic [nv12ns_pkg::DEST_W-1:0]         cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  opcode,
    input  logic [16:0]                           load_address,
    input  logic [7:0]                            load_byte,
    input  logic [nv12ns_pkg::DEST_W-1:0]         dest_x,
    input  logic [nv12ns_pkg::DEST_W-1:0]         dest_y,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [7:0]                            red,
    output logic [7:0]                            green,
    output logic [7:0]                            blue,
    output logic [nv12ns_pkg::OFS_W-1:0]          dest_offset
);

    localparam int SW  = nv12ns_pkg::SIZE_W;
    localparam int DW  = nv12ns_pkg::DEST_W;
    localparam int NW  = nv12ns_pkg::NUM_W;
    localparam int CW  = nv12ns_pkg::CNT_W;
    localparam int AW  = nv12ns_pkg::ADDR_W;
    localparam int BW  = nv12ns_pkg::CBASE_W;
    localparam int XW  = nv12ns_pkg::ACC_W;
    localparam int OW  = nv12ns_pkg::OFS_W;
    localparam int MA  = nv12ns_pkg::MUL_AW;
    localparam int MB  = nv12ns_pkg::MUL_BW;
    localparam int MP  = nv12ns_pkg::MUL_PW;
    localparam int SAW = nv12ns_pkg::STORE_AW;

    logic [7:0] store_mem [nv12ns_pkg::STORE_DEPTH];

    logic [SW-1:0] cfg_sw_reg, cfg_sh_reg, cfg_stride_reg;
    logic [DW-1:0] cfg_dw_reg, cfg_dh_reg;

    nv12ns_pkg::seq_state_t state_reg, state_next;

    logic [DW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [SW-1:0] sw_reg, sw_next, sh_reg, sh_next, stride_reg, stride_next;
    logic [DW-1:0] dw_reg, dw_next, dh_reg, dh_next;
    logic [NW-1:0] num_reg, num_next, sx_reg, sx_next, sy_reg, sy_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] yaddr_reg, yaddr_next, caddr_reg, caddr_next;
    logic [BW-1:0] cbase_reg, cbase_next;
    logic [7:0]    y_reg, y_next, u_reg, u_next, v_reg, v_next;
    logic signed [XW-1:0] acc_reg, acc_next;
    logic [OW-1:0] off_reg, off_next;
    logic [7:0]    red_reg, red_next, green_reg, green_next, blue_reg, blue_next;
    logic [OW-1:0] ofs_reg, ofs_next;

    logic [7:0]    mem_q_reg;
    logic          rd_ok_reg;
    logic [AW-1:0] rd_addr;
    logic [7:0]    byte_val;

    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [MP-1:0] mul_p;

    logic [DW-1:0] div_d;
    logic [DW:0]   trial, diff;
    logic          ge;
    logic signed [XW-1:0] luma;
    logic signed [MB-1:0] du, dv;
    logic [OW-1:0] off_sum;
    logic          in_accept;
    logic [SW-1:0] sw_eff;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != nv12ns_pkg::S_IDLE);
    assign out_valid = (state_reg == nv12ns_pkg::S_OUT);
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign dest_offset = ofs_reg;

    assign mul_p    = mul_a * mul_b;
    assign byte_val = rd_ok_reg ? mem_q_reg : 8'd0;
    assign luma     = $signed({3'b000, y_reg, {nv12ns_pkg::FRAC_W{1'b0}}});
    assign du       = $signed({{(MB-8){1'b0}}, u_reg}) - $signed(MB'(128));
    assign dv       = $signed({{(MB-8){1'b0}}, v_reg}) - $signed(MB'(128));
    assign div_d    = (state_reg == nv12ns_pkg::S_DIV_Y) ? dh_reg : dw_reg;
    assign trial    = {rem_reg, num_reg[NW-1]};
    assign diff     = trial - {1'b0, div_d};
    assign ge       = (trial >= {1'b0, div_d});
    assign off_sum  = off_reg + {{(OW-DW){1'b0}}, dx_reg};
    assign sw_eff   = (cfg_sw_reg == '0) ? SW'(1) : cfg_sw_reg;

    // latch configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_sw_reg     <= nv12ns_pkg::RESET_SOURCE_WIDTH;
            cfg_sh_reg     <= nv12ns_pkg::RESET_SOURCE_HEIGHT;
            cfg_stride_reg <= nv12ns_pkg::RESET_SOURCE_STRIDE;
            cfg_dw_reg     <= nv12ns_pkg::RESET_DEST_WIDTH;
            cfg_dh_reg     <= nv12ns_pkg::RESET_DEST_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nv12ns_pkg::CFG_SOURCE_WIDTH:  cfg_sw_reg     <= cfg_data[SW-1:0];
                nv12ns_pkg::CFG_SOURCE_HEIGHT: cfg_sh_reg     <= cfg_data[SW-1:0];
                nv12ns_pkg::CFG_SOURCE_STRIDE: cfg_stride_reg <= cfg_data[SW-1:0];
                nv12ns_pkg::CFG_DEST_WIDTH:    cfg_dw_reg     <= cfg_data;
                nv12ns_pkg::CFG_DEST_HEIGHT:   cfg_dh_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // write load bytes, read one byte a cycle
    always_ff @(posedge clk)
    begin
        if (in_accept && opcode == nv12ns_pkg::OP_LOAD
            && {15'd0, load_address} < 32'(nv12ns_pkg::STORE_DEPTH))
        begin
            store_mem[load_address[SAW-1:0]] <= load_byte;
        end
        mem_q_reg <= store_mem[rd_addr[SAW-1:0]];
        rd_ok_reg <= ({1'b0, rd_addr} < 32'(nv12ns_pkg::STORE_DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nv12ns_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sw_reg     <= sw_next;
        sh_reg     <= sh_next;
        stride_reg <= stride_next;
        dw_reg     <= dw_next;
        dh_reg     <= dh_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        yaddr_reg  <= yaddr_next;
        cbase_reg  <= cbase_next;
        caddr_reg  <= caddr_next;
        y_reg      <= y_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        acc_reg    <= acc_next;
        off_reg    <= off_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        ofs_reg    <= ofs_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sw_next     = sw_reg;
        sh_next     = sh_reg;
        stride_next = stride_reg;
        dw_next     = dw_reg;
        dh_next     = dh_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        yaddr_next  = yaddr_reg;
        cbase_next  = cbase_reg;
        caddr_next  = caddr_reg;
        y_next      = y_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        acc_next    = acc_reg;
        off_next    = off_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        ofs_next    = ofs_reg;
        rd_addr     = yaddr_reg;
        mul_a       = '0;
        mul_b       = '0;

        case (state_reg)
            nv12ns_pkg::S_IDLE:
            begin
                if (in_accept && opcode == nv12ns_pkg::OP_FETCH)
                begin
                    dx_next     = dest_x;
                    dy_next     = dest_y;
                    sw_next     = sw_eff;
                    sh_next     = (cfg_sh_reg == '0) ? SW'(1) : cfg_sh_reg;
                    stride_next = (cfg_stride_reg == '0) ? sw_eff : cfg_stride_reg;
                    dw_next     = (cfg_dw_reg == '0) ? DW'(1) : cfg_dw_reg;
                    dh_next     = (cfg_dh_reg == '0) ? DW'(1) : cfg_dh_reg;
                    state_next  = nv12ns_pkg::S_MUL_X;
                end
            end
            nv12ns_pkg::S_MUL_X:
            begin
                mul_a      = $signed({{(MA-DW){1'b0}}, dx_reg});
                mul_b      = $signed({{(MB-SW){1'b0}}, sw_reg});
                num_next   = mul_p[NW-1:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = nv12ns_pkg::S_DIV_X;
            end
            nv12ns_pkg::S_DIV_X, nv12ns_pkg::S_DIV_Y:
            begin
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                num_next = {num_reg[NW-2:0], ge};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1))
                begin
                    if (state_reg == nv12ns_pkg::S_DIV_X)
                    begin
                        sx_next    = {num_reg[NW-2:0], ge};
                        state_next = nv12ns_pkg::S_MUL_Y;
                    end
                    else
                    begin
                        sy_next    = {num_reg[NW-2:0], ge};
                        state_next = nv12ns_pkg::S_MUL_YA;
                    end
                end
            end
            nv12ns_pkg::S_MUL_Y:
            begin
                mul_a      = $signed({{(MA-DW){1'b0}}, dy_reg});
                mul_b      = $signed({{(MB-SW){1'b0}}, sh_reg});
                num_next   = mul_p[NW-1:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = nv12ns_pkg::S_DIV_Y;
            end
            nv12ns_pkg::S_MUL_YA:
            begin
                mul_a      = $signed({{(MA-NW){1'b0}}, sy_reg});
                mul_b      = $signed({{(MB-SW){1'b0}}, stride_reg});
                yaddr_next = mul_p[AW-1:0] + {{(AW-NW){1'b0}}, sx_reg};
                state_next = nv12ns_pkg::S_MUL_CB;
            end
            nv12ns_pkg::S_MUL_CB:
            begin
                mul_a      = $signed({{(MA-SW){1'b0}}, stride_reg});
                mul_b      = $signed({{(MB-SW){1'b0}}, sh_reg});
                cbase_next = mul_p[BW-1:0];
                state_next = nv12ns_pkg::S_MUL_CA;
            end
            nv12ns_pkg::S_MUL_CA:
            begin
                mul_a      = $signed({{(MA-NW+1){1'b0}}, sy_reg[NW-1:1]});
                mul_b      = $signed({{(MB-SW){1'b0}}, stride_reg});
                caddr_next = mul_p[AW-1:0] + {{(AW-BW){1'b0}}, cbase_reg}
                           + {{(AW-NW){1'b0}}, sx_reg[NW-1:1], 1'b0};
                state_next = nv12ns_pkg::S_RD_Y;
            end
            nv12ns_pkg::S_RD_Y:
            begin
                rd_addr    = yaddr_reg;
                state_next = nv12ns_pkg::S_RD_U;
            end
            nv12ns_pkg::S_RD_U:
            begin
                rd_addr    = caddr_reg;
                y_next     = byte_val;
                state_next = nv12ns_pkg::S_RD_V;
            end
            nv12ns_pkg::S_RD_V:
            begin
                rd_addr    = caddr_reg + AW'(1);
                u_next     = byte_val;
                state_next = nv12ns_pkg::S_CAP_V;
            end
            nv12ns_pkg::S_CAP_V:
            begin
                v_next     = byte_val;
                state_next = nv12ns_pkg::S_CH_R;
            end
            nv12ns_pkg::S_CH_R:
            begin
                mul_a      = nv12ns_pkg::COEF_RV;
                mul_b      = dv;
                red_next   = nv12ns_pkg::clamp_channel(luma + mul_p[XW-1:0]);
                state_next = nv12ns_pkg::S_CH_G1;
            end
            nv12ns_pkg::S_CH_G1:
            begin
                mul_a      = nv12ns_pkg::COEF_GU;
                mul_b      = du;
                acc_next   = luma - mul_p[XW-1:0];
                state_next = nv12ns_pkg::S_CH_G2;
            end
            nv12ns_pkg::S_CH_G2:
            begin
                mul_a      = nv12ns_pkg::COEF_GV;
                mul_b      = dv;
                green_next = nv12ns_pkg::clamp_channel(acc_reg - mul_p[XW-1:0]);
                state_next = nv12ns_pkg::S_CH_B;
            end
            nv12ns_pkg::S_CH_B:
            begin
                mul_a      = nv12ns_pkg::COEF_BU;
                mul_b      = du;
                blue_next  = nv12ns_pkg::clamp_channel(luma + mul_p[XW-1:0]);
                state_next = nv12ns_pkg::S_OFF_MUL;
            end
            nv12ns_pkg::S_OFF_MUL:
            begin
                mul_a      = $signed({{(MA-DW){1'b0}}, dy_reg});
                mul_b      = $signed({{(MB-DW){1'b0}}, dw_reg});
                off_next   = mul_p[OW-1:0];
                state_next = nv12ns_pkg::S_OFF_ADD;
            end
            nv12ns_pkg::S_OFF_ADD:
            begin
                ofs_next   = {off_sum[OW-2:0], 1'b0} + off_sum;
                state_next = nv12ns_pkg::S_OUT;
            end
            nv12ns_pkg::S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = nv12ns_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nv12ns_pkg::S_IDLE;
            end
        endcase
    end

endmodule
